// ===== design/scp_pkg.sv =====
// shared constants, mode and register codes for the sensor point calibration block
// no dependencies
package scp_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned CfgIdxW      = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegMode,
    RegX1,
    RegY1,
    RegX2,
    RegY2,
    RegX3,
    RegY3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ModeNone,
    ModeOffset,
    ModeLinear,
    ModeQuad
  } mode_e;

endpackage

// ===== design/sensor_point_calibration.sv =====
// throughput: one transaction per cycle, set by the restoring divider that retires
// one quotient bit per pipeline stage; the whole pipeline holds while the result waits
// reset: rst_ni clears mode and all points to zero and empties the pipeline
// top level: multi point calibration pipeline, depends on scp_pkg
// coefficient products, restoring divider and saturation in one pipeline
module sensor_point_calibration #(
  parameter int unsigned DATA_WIDTH = scp_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [DATA_WIDTH-1:0]  corrected_o,
  output logic                          degenerate_o,
  output logic                          saturated_o
);
  import scp_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int D1   = DW + 1;
  localparam int W2   = 2 * D1;
  localparam int W3   = W2 + DW;
  localparam int W4   = W3 + D1;
  localparam int NW   = W4 + 2;
  localparam int DENW = 3 * D1;

  // configuration registers
  mode_e                 mode_q;
  logic signed [DW-1:0]  x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNone;
      x1_q   <= '0;
      y1_q   <= '0;
      x2_q   <= '0;
      y2_q   <= '0;
      x3_q   <= '0;
      y3_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode: mode_q <= mode_e'(cfg_data_i[1:0]);
        RegX1:   x1_q   <= cfg_data_i;
        RegY1:   y1_q   <= cfg_data_i;
        RegX2:   x2_q   <= cfg_data_i;
        RegY2:   y2_q   <= cfg_data_i;
        RegX3:   x3_q   <= cfg_data_i;
        RegY3:   y3_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coefficients derived from configuration, free running
  logic signed [D1-1:0]    c_d21_q, c_d12_q, c_d13_q, c_d23_q, c_dy21_q;
  logic                    deg_q;
  logic signed [DW+D1-1:0] l2_q;
  logic signed [W2-1:0]    dd_q;
  logic signed [2*D1-1:0]  ddh_q;
  logic signed [2*D1:0]    ddl_q;
  logic signed [DENW-1:0]  den3_q;
  logic [DENW-1:0]         dm_q;
  logic                    dneg_q;

  logic signed [D1-1:0]    c_d21_d, c_d12_d, c_d13_d, c_d23_d, c_dy21_d;
  logic                    deg_d;
  logic signed [DW+D1-1:0] l2_d;
  logic signed [W2-1:0]    dd_d;
  logic signed [2*D1-1:0]  ddh_d;
  logic signed [2*D1:0]    ddl_d;
  logic signed [DENW-1:0]  den3_d;
  logic signed [DENW-1:0]  dsel;
  logic [DENW-1:0]         dm_d;
  logic                    dneg_d;

  always_comb begin
    c_d21_d  = D1'(x2_q) - D1'(x1_q);
    c_d12_d  = D1'(x1_q) - D1'(x2_q);
    c_d13_d  = D1'(x1_q) - D1'(x3_q);
    c_d23_d  = D1'(x2_q) - D1'(x3_q);
    c_dy21_d = D1'(y2_q) - D1'(y1_q);
    case (mode_q)
      ModeLinear: deg_d = (x1_q == x2_q);
      ModeQuad:   deg_d = (x1_q == x2_q) || (x1_q == x3_q) || (x2_q == x3_q);
      default:    deg_d = 1'b0;
    endcase
    l2_d  = (DW+D1)'(y1_q) * (DW+D1)'(c_d21_q);
    dd_d  = W2'(c_d12_q) * W2'(c_d13_q);
    ddh_d = (2*D1)'($signed(dd_q[W2-1:D1])) * (2*D1)'(c_d23_q);
    ddl_d = (2*D1+1)'($signed({1'b0, dd_q[D1-1:0]})) * (2*D1+1)'(c_d23_q);
    den3_d = (DENW'(ddh_q) <<< D1) + DENW'(ddl_q);
    case (mode_q)
      ModeLinear: dsel = DENW'(c_d21_q);
      ModeQuad:   dsel = den3_q;
      default:    dsel = DENW'(1);
    endcase
    dneg_d = dsel[DENW-1];
    dm_d   = dneg_d ? DENW'(-dsel) : DENW'(dsel);
  end

  always_ff @(posedge clk_i) begin
    c_d21_q  <= c_d21_d;
    c_d12_q  <= c_d12_d;
    c_d13_q  <= c_d13_d;
    c_d23_q  <= c_d23_d;
    c_dy21_q <= c_dy21_d;
    deg_q    <= deg_d;
    l2_q     <= l2_d;
    dd_q     <= dd_d;
    ddh_q    <= ddh_d;
    ddl_q    <= ddl_d;
    den3_q   <= den3_d;
    dm_q     <= dm_d;
    dneg_q   <= dneg_d;
  end

  // pipeline control
  logic        adv;
  logic [8:0]  vld_q;
  logic        dv_q [DW+1];
  logic        out_valid_q;

  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= DW; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q    <= {vld_q[7:0], in_valid_i};
      dv_q[0]  <= vld_q[8];
      for (int i = 1; i <= DW; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
      out_valid_q <= dv_q[DW];
    end
  end

  // datapath registers
  logic signed [DW-1:0]      s1_s_q, s2_s_q, s3_s_q, s4_s_q, s5_s_q, s6_s_q, s7_s_q;
  logic signed [DW-1:0]      s8_s_q, s9_s_q;
  logic signed [D1-1:0]      s2_a_q, s2_b_q, s2_c_q, s3_a_q;
  logic signed [W2-1:0]      s3_p2_q;
  logic signed [W2-1:0]      s3_m_q [3];
  logic signed [D1:0]        s4_n1_q, s5_n1_q, s6_n1_q, s7_n1_q;
  logic signed [W2:0]        s4_n2_q, s5_n2_q, s6_n2_q, s7_n2_q;
  logic signed [W2-2:0]      s4_h_q [3];
  logic signed [W2-1:0]      s4_l_q [3];
  logic signed [W3-1:0]      s5_u_q [3];
  logic signed [2*D1:0]      s6_p0_q [3];
  logic signed [2*D1:0]      s6_p1_q [3];
  logic signed [DW+D1-1:0]   s6_p2_q [3];
  logic signed [W4-1:0]      s7_t_q [3];
  logic signed [NW-1:0]      s8_n_q;
  logic [NW-1:0]             s9_nm_q;
  logic                      s9_neg_q;
  logic [NW-1:0]             dr_q [DW+1];
  logic [DW-1:0]             dq_q [DW+1];
  logic                      ovf_q [DW+1];
  logic                      qn_q [DW+1];
  logic signed [DW-1:0]      ds_q [DW+1];
  logic signed [DW-1:0]      corrected_q;
  logic                      degenerate_q, saturated_q;

  logic signed [DW-1:0]      y_arr [3];
  logic signed [D1-1:0]      d_arr [3];
  logic signed [D1-1:0]      s2_a_d, s2_b_d, s2_c_d;
  logic signed [W2-1:0]      s3_p2_d;
  logic signed [W2-1:0]      s3_m_d [3];
  logic signed [D1:0]        s4_n1_d;
  logic signed [W2:0]        s4_n2_d;
  logic signed [W2-2:0]      s4_h_d [3];
  logic signed [W2-1:0]      s4_l_d [3];
  logic signed [W3-1:0]      s5_u_d [3];
  logic signed [2*D1:0]      s6_p0_d [3];
  logic signed [2*D1:0]      s6_p1_d [3];
  logic signed [DW+D1-1:0]   s6_p2_d [3];
  logic signed [W4-1:0]      s7_t_d [3];
  logic signed [NW-1:0]      s8_n_d;
  logic [NW-1:0]             s9_nm_d;
  logic                      s9_neg_d;
  logic                      ovf0_d;
  logic [NW-1:0]             dr_d [DW+1];
  logic [DW-1:0]             dq_d [DW+1];
  logic [NW-1:0]             dsh;
  logic                      ge;
  logic signed [DW-1:0]      corrected_d;
  logic                      degenerate_d, saturated_d;
  logic [DW-1:0]             mag;

  always_comb begin
    y_arr[0] = y1_q;
    y_arr[1] = y2_q;
    y_arr[2] = y3_q;
    d_arr[0] = c_d23_q;
    d_arr[1] = c_d13_q;
    d_arr[2] = c_d12_q;

    s2_a_d = D1'(s1_s_q) - D1'(x1_q);
    s2_b_d = D1'(s1_s_q) - D1'(x2_q);
    s2_c_d = D1'(s1_s_q) - D1'(x3_q);

    s3_p2_d   = W2'(c_dy21_q) * W2'(s2_a_q);
    s3_m_d[0] = W2'(s2_b_q) * W2'(s2_c_q);
    s3_m_d[1] = W2'(s2_a_q) * W2'(s2_c_q);
    s3_m_d[2] = W2'(s2_a_q) * W2'(s2_b_q);

    s4_n1_d = (D1+1)'(s3_a_q) + (D1+1)'(y1_q);
    s4_n2_d = (W2+1)'(l2_q) + (W2+1)'(s3_p2_q);
    for (int k = 0; k < 3; k++) begin
      s4_h_d[k] = (W2-1)'($signed(s3_m_q[k][W2-1:D1])) * (W2-1)'(y_arr[k]);
      s4_l_d[k] = W2'($signed({1'b0, s3_m_q[k][D1-1:0]})) * W2'(y_arr[k]);
      s5_u_d[k] = (W3'(s4_h_q[k]) <<< D1) + W3'(s4_l_q[k]);
      s6_p0_d[k] = (2*D1+1)'($signed({1'b0, s5_u_q[k][D1-1:0]}))
                   * (2*D1+1)'(d_arr[k]);
      s6_p1_d[k] = (2*D1+1)'($signed({1'b0, s5_u_q[k][2*D1-1:D1]}))
                   * (2*D1+1)'(d_arr[k]);
      s6_p2_d[k] = (DW+D1)'($signed(s5_u_q[k][W3-1:2*D1])) * (DW+D1)'(d_arr[k]);
      s7_t_d[k] = (W4'(s6_p2_q[k]) <<< (2*D1)) + (W4'(s6_p1_q[k]) <<< D1)
                  + W4'(s6_p0_q[k]);
    end

    case (mode_q)
      ModeQuad:   s8_n_d = NW'(s7_t_q[0]) - NW'(s7_t_q[1]) + NW'(s7_t_q[2]);
      ModeLinear: s8_n_d = NW'(s7_n2_q);
      default:    s8_n_d = NW'(s7_n1_q);
    endcase

    s9_neg_d = s8_n_q[NW-1];
    s9_nm_d  = s9_neg_d ? NW'(-s8_n_q) : NW'(s8_n_q);

    ovf0_d = s9_nm_q >= (NW'(dm_q) << DW);

    // restoring division, one quotient bit per stage, msb first
    dr_d[0] = s9_nm_q;
    dq_d[0] = '0;
    for (int g = 0; g < DW; g++) begin
      dsh         = NW'(dm_q) << (DW - 1 - g);
      ge          = dr_q[g] >= dsh;
      dr_d[g+1]   = ge ? dr_q[g] - dsh : dr_q[g];
      dq_d[g+1]   = dq_q[g];
      dq_d[g+1][DW-1-g] = ge;
    end

    // sign and saturation
    mag          = dq_q[DW];
    corrected_d  = ds_q[DW];
    degenerate_d = 1'b0;
    saturated_d  = 1'b0;
    if (mode_q == ModeNone) begin
      corrected_d = ds_q[DW];
    end else if (deg_q) begin
      degenerate_d = 1'b1;
    end else if (qn_q[DW]) begin
      if (ovf_q[DW] || (mag[DW-1] && (|mag[DW-2:0]))) begin
        corrected_d = {1'b1, {(DW-1){1'b0}}};
        saturated_d = 1'b1;
      end else begin
        corrected_d = -$signed(mag);
      end
    end else begin
      if (ovf_q[DW] || mag[DW-1]) begin
        corrected_d = {1'b0, {(DW-1){1'b1}}};
        saturated_d = 1'b1;
      end else begin
        corrected_d = $signed(mag);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_s_q  <= sample_i;
      s2_s_q  <= s1_s_q;
      s2_a_q  <= s2_a_d;
      s2_b_q  <= s2_b_d;
      s2_c_q  <= s2_c_d;
      s3_s_q  <= s2_s_q;
      s3_a_q  <= s2_a_q;
      s3_p2_q <= s3_p2_d;
      s4_s_q  <= s3_s_q;
      s4_n1_q <= s4_n1_d;
      s4_n2_q <= s4_n2_d;
      s5_s_q  <= s4_s_q;
      s5_n1_q <= s4_n1_q;
      s5_n2_q <= s4_n2_q;
      s6_s_q  <= s5_s_q;
      s6_n1_q <= s5_n1_q;
      s6_n2_q <= s5_n2_q;
      s7_s_q  <= s6_s_q;
      s7_n1_q <= s6_n1_q;
      s7_n2_q <= s6_n2_q;
      for (int k = 0; k < 3; k++) begin
        s3_m_q[k]  <= s3_m_d[k];
        s4_h_q[k]  <= s4_h_d[k];
        s4_l_q[k]  <= s4_l_d[k];
        s5_u_q[k]  <= s5_u_d[k];
        s6_p0_q[k] <= s6_p0_d[k];
        s6_p1_q[k] <= s6_p1_d[k];
        s6_p2_q[k] <= s6_p2_d[k];
        s7_t_q[k]  <= s7_t_d[k];
      end
      s8_s_q   <= s7_s_q;
      s8_n_q   <= s8_n_d;
      s9_s_q   <= s8_s_q;
      s9_nm_q  <= s9_nm_d;
      s9_neg_q <= s9_neg_d;
      dr_q[0]  <= dr_d[0];
      dq_q[0]  <= dq_d[0];
      ovf_q[0] <= ovf0_d;
      qn_q[0]  <= s9_neg_q ^ dneg_q;
      ds_q[0]  <= s9_s_q;
      for (int g = 1; g <= DW; g++) begin
        dr_q[g]  <= dr_d[g];
        dq_q[g]  <= dq_d[g];
        ovf_q[g] <= ovf_q[g-1];
        qn_q[g]  <= qn_q[g-1];
        ds_q[g]  <= ds_q[g-1];
      end
      corrected_q  <= corrected_d;
      degenerate_q <= degenerate_d;
      saturated_q  <= saturated_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign corrected_o  = corrected_q;
  assign degenerate_o = degenerate_q;
  assign saturated_o  = saturated_q;

endmodule

// ===== bench/sensor_point_calibration_tb.sv =====
// self-checking testbench for the sensor point calibration pipeline
// depends on scp_pkg and sensor_point_calibration; scoreboard predicts each transaction
`timescale 1ns / 100ps

module sensor_point_calibration_tb;
  import scp_pkg::*;

  localparam int unsigned DW = 32;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int SettleCycles = 60;
  localparam int WatchdogLimit = 4000;
  localparam logic signed [DW-1:0] SMax = 32'sh7fffffff;
  localparam logic signed [DW-1:0] SMin = 32'sh80000000;

  typedef logic signed [191:0] wide_t;
  typedef struct packed {
    logic signed [DW-1:0] corrected;
    logic                 degenerate;
    logic                 saturated;
  } cal_t;

  class cal_scoreboard;
    logic [1:0] mode;
    logic signed [DW-1:0] xp[3];
    logic signed [DW-1:0] yp[3];
    cal_t expected_q[$];
    int mismatches;
    int checked;

    function new();
      mode = ModeNone;
      for (int i = 0; i < 3; i++) begin
        xp[i] = '0;
        yp[i] = '0;
      end
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [DW-1:0] val);
      case (idx)
        RegMode: mode = val[1:0];
        RegX1: xp[0] = val;
        RegY1: yp[0] = val;
        RegX2: xp[1] = val;
        RegY2: yp[1] = val;
        RegX3: xp[2] = val;
        RegY3: yp[2] = val;
        default: ;
      endcase
    endfunction

    function cal_t calibrate(logic signed [DW-1:0] smp);
      cal_t r;
      wide_t s, x1, x2, x3, y1, y2, y3, den, q, hi, lo;
      r.corrected = smp;
      r.degenerate = 1'b0;
      r.saturated = 1'b0;
      s = wide_t'(smp);
      x1 = wide_t'(xp[0]); x2 = wide_t'(xp[1]); x3 = wide_t'(xp[2]);
      y1 = wide_t'(yp[0]); y2 = wide_t'(yp[1]); y3 = wide_t'(yp[2]);
      hi = wide_t'(SMax);
      lo = wide_t'(SMin);
      case (mode)
        ModeNone: return r;
        ModeOffset: q = s - x1 + y1;
        ModeLinear: begin
          if (x1 == x2) begin
            r.degenerate = 1'b1;
            return r;
          end
          den = x2 - x1;
          q = (y1 * den + (y2 - y1) * (s - x1)) / den;
        end
        default: begin
          if (x1 == x2 || x1 == x3 || x2 == x3) begin
            r.degenerate = 1'b1;
            return r;
          end
          den = (x1 - x2) * (x1 - x3) * (x2 - x3);
          q = (y1 * (s - x2) * (s - x3) * (x2 - x3)
             - y2 * (s - x1) * (s - x3) * (x1 - x3)
             + y3 * (s - x1) * (s - x2) * (x1 - x2)) / den;
        end
      endcase
      if (q > hi) begin
        q = hi;
        r.saturated = 1'b1;
      end else if (q < lo) begin
        q = lo;
        r.saturated = 1'b1;
      end
      r.corrected = q[DW-1:0];
      return r;
    endfunction

    function void note(logic signed [DW-1:0] smp);
      expected_q.insert(expected_q.size(), calibrate(smp));
    endfunction

    function void check(cal_t act);
      cal_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: corrected %h deg %b sat %b",
                   act.corrected, act.degenerate, act.saturated);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r !== act) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%b/%b actual %h/%b/%b",
                   exp_r.corrected, exp_r.degenerate, exp_r.saturated,
                   act.corrected, act.degenerate, act.saturated);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [DW-1:0] sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DW-1:0] corrected_o;
  logic degenerate_o;
  logic saturated_o;

  cal_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  int n_sent = 0;
  int n_settings = 0;

  sensor_point_calibration #(.DATA_WIDTH(DW)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni)
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // transactions are sampled mid-cycle; they complete at the following rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check('{corrected_o, degenerate_o, saturated_o});
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired with %0d results pending", sb.expected_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push(input logic signed [DW-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= smp;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sb.note(smp);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic setup(input logic [1:0] m, input logic [DW-1:0] x1, y1, x2, y2, x3, y3);
    drain();
    write_reg(RegMode, {30'd0, m});
    write_reg(RegX1, x1);
    write_reg(RegY1, y1);
    write_reg(RegX2, x2);
    write_reg(RegY2, y2);
    write_reg(RegX3, x3);
    write_reg(RegY3, y3);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [DW-1:0] rand_point(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(1, 0) ? SMax - $urandom_range(3) : SMin + $urandom_range(3);
      2: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom();
      1: return sb.xp[$urandom_range(2)] + $signed($urandom_range(64)) - 32;
      2: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
      default: return $urandom_range(1, 0) ? SMax - $urandom_range(7) : SMin + $urandom_range(7);
    endcase
  endfunction

  initial begin
    logic [DW-1:0] p[6];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pass through, offset, linear, quadratic and their degenerate forms
    push(0); push(SMax); push(SMin); push(-1);
    setup(ModeOffset, SMin, SMax, 0, 0, 0, 0);
    push(SMax); push(SMin); push(0);
    setup(ModeOffset, SMax, SMin, 0, 0, 0, 0);
    push(SMin); push(SMax);
    setup(ModeLinear, 32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 5, 0, 0);
    push(7); push(SMax);
    setup(ModeLinear, 0, 0, 32'sh0001_0000, 32'sh0003_0000, 0, 0);
    push(32'sh0002_0000); push(SMax); push(SMin); push(-5);
    setup(ModeQuad, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 0, 3);
    push(9);
    setup(ModeQuad, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000);
    push(32'sh0003_0000); push(-32'sh0002_8000); push(SMax); push(SMin);
    drain();
    write_reg(RegUnused, 32'hdead_beef);
    cfg_we_i <= 1'b0;
    push(32'sh0000_8000);

    for (int blk = 0; blk < 11; blk++) begin
      send_idle_pct = (blk < 4) ? 8 : (blk < 8) ? 76 : 0;
      recv_idle_pct = (blk < 4) ? 76 : (blk < 8) ? 8 : 0;
      for (int i = 0; i < 6; i++) p[i] = rand_point($urandom_range(3));
      if ($urandom_range(4) == 0) p[2] = p[0];
      setup(blk < 4 ? blk[1:0] : 2'($urandom_range(3)), p[0], p[1], p[2], p[3], p[4], p[5]);
      for (int i = 0; i < 150; i++) begin
        push(rand_sample());
        if (blk == 5 && i == 75) drain();
      end
    end

    drain();
    $display("run covered %0d samples over %0d register settings, %0d results checked",
             n_sent, n_settings, sb.checked);
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
